>>> rtl/apwf_pkg.sv
// Shared types and constants for the all-phase window and fold block.
package apwf_pkg;

   // Frame of 2N samples; a power of two from 8 up to 1024 (POS_W is 9 bits).
   localparam int FRAME_LENGTH = 512 * 2;
   localparam int HALF_LEN     = FRAME_LENGTH / 2;
   localparam int CNT_W        = $clog2(FRAME_LENGTH);
   localparam int ADDR_W       = CNT_W - 1;
   localparam int STORE_DEPTH  = HALF_LEN - 1;

   localparam int SAMPLE_W     = 13;
   localparam int FOLD_W       = 22;
   localparam int POS_W        = 9;
   localparam int MUL_W        = SAMPLE_W + CNT_W + 1;

   localparam int REQ_DATA_W   = 32;
   localparam int RSP_DATA_W   = 56;

   // One sample pair on its way from the input register to the result register.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] volt;
      logic signed [SAMPLE_W-1:0] curr;
      logic [CNT_W-1:0]           weight;
      logic                       store;
      logic                       add;
      logic                       emit;
      logic [ADDR_W-1:0]          wr_addr;
      logic [POS_W-1:0]           pos;
      logic                       last;
   } stage_type;

   typedef struct packed {
      logic signed [FOLD_W-1:0] volt;
      logic signed [FOLD_W-1:0] curr;
   } pair_type;

endpackage

>>> rtl/apwf_ctrl.sv
// Sample counter, window weight and input register.
module apwf_ctrl
   import apwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  advance,
   output logic                  stage_valid,
   output stage_type             stage,
   output logic                  rd_en,
   output logic [ADDR_W-1:0]     rd_addr
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             valid_ff, valid_in;
   stage_type        stage_ff, stage_in;
   logic             accept;
   logic             frame_end;
   logic             first_half;
   logic [CNT_W-1:0] pos_full;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign frame_end  = (count_ff == CNT_W'(FRAME_LENGTH - 1));
   assign first_half = (count_ff < CNT_W'(HALF_LEN));
   assign pos_full   = count_ff - CNT_W'(HALF_LEN - 1);

   // Second half reads the entry stored half a frame earlier; the dropped
   // last sample of the frame reads nothing.
   assign rd_en   = accept && !first_half && !frame_end;
   assign rd_addr = count_ff[ADDR_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = frame_end ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = !frame_end;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      stage_in.volt    = $signed(req_tdata[SAMPLE_W-1:0]);
      stage_in.curr    = $signed(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
      stage_in.weight  = first_half ? count_ff + CNT_W'(1)
                                    : CNT_W'(FRAME_LENGTH - 1) - count_ff;
      stage_in.store   = (count_ff < CNT_W'(HALF_LEN - 1));
      stage_in.add     = !first_half;
      stage_in.emit    = !stage_in.store;
      stage_in.wr_addr = count_ff[ADDR_W-1:0];
      stage_in.pos     = POS_W'(pos_full);
      stage_in.last    = (count_ff == CNT_W'(FRAME_LENGTH - 2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !frame_end) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

>>> rtl/apwf_store.sv
// First-half store of weighted samples for both channels.
module apwf_store
   import apwf_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pair_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pair_type          rd_data
);

   logic [FOLD_W-1:0] volt_mem [STORE_DEPTH];
   logic [FOLD_W-1:0] curr_mem [STORE_DEPTH];
   pair_type          rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         volt_mem[wr_addr] <= wr_data.volt;
         curr_mem[wr_addr] <= wr_data.curr;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff.volt <= $signed(volt_mem[rd_addr]);
         rd_ff.curr <= $signed(curr_mem[rd_addr]);
      end
   end

   assign rd_data = rd_ff;

endmodule

>>> rtl/apwf_fold.sv
// Window multiply, fold add and result register.
module apwf_fold
   import apwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  stage_valid,
   input  stage_type             stage,
   input  pair_type              rd_data,
   output pair_type              weighted,
   output logic                  advance,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic signed [MUL_W-1:0] volt_prod;
   logic signed [MUL_W-1:0] curr_prod;
   pair_type                sum;
   logic                    out_valid_ff, out_valid_in;
   pair_type                out_pair_ff;
   logic [POS_W-1:0]        out_pos_ff;
   logic                    out_last_ff;
   logic                    load;

   assign volt_prod = MUL_W'(stage.volt) * MUL_W'($signed({1'b0, stage.weight}));
   assign curr_prod = MUL_W'(stage.curr) * MUL_W'($signed({1'b0, stage.weight}));

   // Wrap to the result width; the fold add wraps the same way.
   assign weighted.volt = FOLD_W'(volt_prod);
   assign weighted.curr = FOLD_W'(curr_prod);

   assign sum.volt = weighted.volt + (stage.add ? rd_data.volt : FOLD_W'(0));
   assign sum.curr = weighted.curr + (stage.add ? rd_data.curr : FOLD_W'(0));

   assign advance = !out_valid_ff || rsp_tready;
   assign load    = advance && stage_valid && stage.emit;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = stage_valid && stage.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_pair_ff <= sum;
         out_pos_ff  <= stage.pos;
         out_last_ff <= stage.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_pos_ff, out_pair_ff.curr, out_pair_ff.volt});

endmodule

>>> rtl/all_phase_window_fold.sv
// Top level of the two-channel all-phase window and fold block.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tdata: volt_sample, curr_sample
//   rsp      out        rsp_tvalid/rsp_tready  tdata: volt_folded, curr_folded,
//                                              out_position; tlast: frame_last
//
// One sample pair is taken every cycle while the result side is not stalled; a
// result leaves through the input register and then the result register, around
// the multiply and fold add. The store read is issued at request time.
// Reset (synchronous, active high) returns the counter to the start of frame
// and empties both registers; the store holds no reset value.
// A stalled result holds its register; the input register still takes a request
// while it is empty, then req_tready drops until the result is taken.
module all_phase_window_fold
   import apwf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [12:0] volt_sample, [25:13] curr_sample, [31:26] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [21:0] volt_folded, [43:22] curr_folded, [52:44] out_position, [55:53] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic              advance;
   logic              stage_valid;
   stage_type         stage;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   pair_type          rd_data;
   pair_type          weighted;
   logic              wr_en;

   apwf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr)
   );

   // Write once, as the sample leaves the input register.
   assign wr_en = stage_valid && stage.store && advance;

   apwf_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (stage.wr_addr),
      .wr_data (weighted),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   apwf_fold u_fold (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage       (stage),
      .rd_data     (rd_data),
      .weighted    (weighted),
      .advance     (advance),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

>>> rtl/apwf_checker.sv
// Port-level checks for the window and fold block, bound to the top level.
module apwf_checker
   import apwf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   localparam int POS_LO = 2 * FOLD_W;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Frame end marks exactly the last output position.
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[POS_LO+POS_W-1:POS_LO]
                                    == POS_W'(HALF_LEN - 1))))
      else $error("frame end does not match last position");

   // A ready result side always frees the input side.
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while result side ready");

endmodule

bind all_phase_window_fold apwf_checker u_apwf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> verif/tb_all_phase_window_fold.sv
// Self-checking testbench for the two-channel all-phase window and fold block.
`timescale 1ns / 1ps

module tb_all_phase_window_fold;
   import apwf_pkg::*;

   localparam int TOTAL_ITEMS  = 800;
   localparam int CALM_TAIL    = 250;
   localparam int HOLD_AFTER   = 10;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] volt;
      logic signed [SAMPLE_W-1:0] curr;
   } sample_pair_type;

   typedef struct packed {
      logic [FOLD_W-1:0] volt;
      logic [FOLD_W-1:0] curr;
      logic [POS_W-1:0]  pos;
      logic              last;
   } fold_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   all_phase_window_fold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   sample_pair_type samples_waiting[$];
   fold_result_type folds_due[$];

   logic signed [SAMPLE_W-1:0] corner_codes[8] = '{
      -13'sd4096, 13'sd4095, 13'sd0, -13'sd1, 13'sd1, -13'sd4095, 13'h0AAA, 13'h1555
   };

   // window position and first-half stores of the predictor
   int                  frame_pos = 0;
   longint              volt_half[HALF_LEN-1];
   longint              curr_half[HALF_LEN-1];

   int                  mismatches  = 0;
   int                  results_got = 0;
   int                  cycle_count = 0;
   logic                quiet = 1'b0;
   int                  send_gap = 0;
   int                  stall_left = 0;
   int                  hold_left = 0;
   logic                held_once = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic logic signed [SAMPLE_W-1:0] random_code();
      if ($urandom_range(0, 3) == 0)
         return corner_codes[$urandom_range(0, 7)];
      return SAMPLE_W'($urandom);
   endfunction

   // Weight one sample pair; store it as first half, or fold it against the stored first half and queue the result.
   task automatic fold_predict(input logic signed [SAMPLE_W-1:0] volt,
                               input logic signed [SAMPLE_W-1:0] curr);
      int              k;
      int              n;
      int              weight;
      longint          volt_w;
      longint          curr_w;
      fold_result_type due;
      k = frame_pos;
      if (k == FRAME_LENGTH - 1) begin
         frame_pos = 0;
      end else begin
         weight = (k < HALF_LEN) ? k + 1 : FRAME_LENGTH - 1 - k;
         volt_w = longint'(volt) * weight;
         curr_w = longint'(curr) * weight;
         if (k < HALF_LEN - 1) begin
            volt_half[k] = volt_w;
            curr_half[k] = curr_w;
         end else begin
            n = k - (HALF_LEN - 1);
            if (n > 0) begin
               volt_w += volt_half[n-1];
               curr_w += curr_half[n-1];
            end
            due.volt = volt_w[FOLD_W-1:0];
            due.curr = curr_w[FOLD_W-1:0];
            due.pos  = n[POS_W-1:0];
            due.last = (n == HALF_LEN - 1);
            folds_due.push_back(due);
         end
         frame_pos = k + 1;
      end
   endtask

   task automatic report_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   initial begin
      sample_pair_type pair;
      for (int i = 0; i < 8; i++) begin
         pair.volt = corner_codes[i];
         pair.curr = corner_codes[7-i];
         samples_waiting.push_back(pair);
         pair.curr = corner_codes[i];
         samples_waiting.push_back(pair);
      end
      for (int idx = 16; idx < TOTAL_ITEMS; idx++) begin
         pair.volt = random_code();
         pair.curr = random_code();
         // hit the full-weight centre sample with the extreme codes
         if (idx == HALF_LEN - 1) begin
            pair.volt = 13'sd4095;
            pair.curr = -13'sd4096;
         end else if (idx == FRAME_LENGTH + HALF_LEN - 1) begin
            pair.volt = -13'sd4096;
            pair.curr = -13'sd4096;
         end
         samples_waiting.push_back(pair);
      end
   end

   // request driver
   always @(posedge clock) begin
      sample_pair_type next_pair;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            fold_predict(req_tdata[SAMPLE_W-1:0], req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
         quiet <= (samples_waiting.size() < CALM_TAIL);
         // hold a request the block has not taken yet
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (samples_waiting.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(1, 9) - 1;
               req_tvalid <= 1'b0;
            end else begin
               next_pair = samples_waiting.pop_front();
               req_tdata  <= {{(REQ_DATA_W-2*SAMPLE_W){1'b0}}, next_pair.curr, next_pair.volt};
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // result ready, with one long hold-off to back up the input side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_once && results_got >= HOLD_AFTER) begin
         held_once = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      fold_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (folds_due.size() == 0) begin
            $error("result with no request pending: tdata 0x%0h tlast %0b",
                   rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = folds_due.pop_front();
            report_field("volt_folded", want.volt, rsp_tdata[FOLD_W-1:0]);
            report_field("curr_folded", want.curr, rsp_tdata[2*FOLD_W-1:FOLD_W]);
            report_field("out_position", want.pos, rsp_tdata[2*FOLD_W+POS_W-1:2*FOLD_W]);
            report_field("frame_last", want.last, rsp_tlast);
         end
         results_got <= results_got + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_all_phase_window_fold NOT OK");
         $finish;
      end
   end

   initial begin
      wait (!reset);
      while (samples_waiting.size() != 0 || req_tvalid)
         @(negedge clock);
      while (folds_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && folds_due.size() == 0)
         $display("tb_all_phase_window_fold OK");
      else
         $display("tb_all_phase_window_fold NOT OK");
      $finish;
   end

endmodule

>>> files.f
rtl/apwf_pkg.sv
rtl/apwf_ctrl.sv
rtl/apwf_store.sv
rtl/apwf_fold.sv
rtl/all_phase_window_fold.sv
rtl/apwf_checker.sv
verif/tb_all_phase_window_fold.sv
